### rtl/core/bvm_pkg.sv
// Shared types, codes and the font table of the CHIP-8 execute block.
package bvm_pkg;

  localparam int MemAw = 12;
  localparam int MemDepth = 4096;
  localparam int ScrRows = 32;
  localparam int FontLen = 80;

  // Item kinds.
  localparam logic [2:0] KIND_EXEC = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_RDMEM = 3'd2;
  localparam logic [2:0] KIND_RDSCR = 3'd3;
  localparam logic [2:0] KIND_RDREG = 3'd4;

  // Special opcodes and nibble or byte codes.
  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;
  localparam logic [3:0] TOP_SYS = 4'h0;
  localparam logic [3:0] TOP_JP = 4'h1;
  localparam logic [3:0] TOP_CALL = 4'h2;
  localparam logic [3:0] TOP_SEQI = 4'h3;
  localparam logic [3:0] TOP_SNEI = 4'h4;
  localparam logic [3:0] TOP_SEQ = 4'h5;
  localparam logic [3:0] TOP_LDI = 4'h6;
  localparam logic [3:0] TOP_ADDI = 4'h7;
  localparam logic [3:0] TOP_ALU = 4'h8;
  localparam logic [3:0] TOP_SNE = 4'h9;
  localparam logic [3:0] TOP_LDIDX = 4'hA;
  localparam logic [3:0] TOP_JPV0 = 4'hB;
  localparam logic [3:0] TOP_DRAW = 4'hD;
  localparam logic [3:0] TOP_MISC = 4'hF;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] MISC_GETDT = 8'h07;
  localparam logic [7:0] MISC_SETDT = 8'h15;
  localparam logic [7:0] MISC_SETST = 8'h18;
  localparam logic [7:0] MISC_ADDI = 8'h1E;
  localparam logic [7:0] MISC_FONT = 8'h29;
  localparam logic [7:0] MISC_BCD = 8'h33;
  localparam logic [7:0] MISC_STORE = 8'h55;
  localparam logic [7:0] MISC_LOAD = 8'h65;

  localparam logic [11:0] PC_RESET = 12'h200;

  localparam logic [7:0] FONT [FontLen] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // Controller states, one-hot.
  typedef enum logic [11:0] {
    ST_CLR  = 12'b0000_0000_0001,
    ST_IDLE = 12'b0000_0000_0010,
    ST_RDX  = 12'b0000_0000_0100,
    ST_RDY  = 12'b0000_0000_1000,
    ST_EXEC = 12'b0000_0001_0000,
    ST_BCD  = 12'b0000_0010_0000,
    ST_STO  = 12'b0000_0100_0000,
    ST_LRD  = 12'b0000_1000_0000,
    ST_LWR  = 12'b0001_0000_0000,
    ST_DRD  = 12'b0010_0000_0000,
    ST_DWR  = 12'b0100_0000_0000,
    ST_FIN  = 12'b1000_0000_0000
  } state_t;

  // Which sequence an item needs after its execute state.
  typedef enum logic [2:0] {
    PATH_SIMPLE,
    PATH_BCD,
    PATH_STORE,
    PATH_LOAD,
    PATH_DRAW
  } path_t;

  typedef struct packed {
    state_t step;
    logic   load;
  } cmd_t;

  typedef struct packed {
    path_t path;
    logic  clr_last;
    logic  cnt_eq_x;
    logic  cnt_eq_2;
    logic  cnt_eq_nm1;
    logic  n_zero;
  } status_t;

endpackage

### rtl/core/bvm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/bvm_ctrl.sv
// Controller state machine that sequences each item through the datapath.
module bvm_ctrl
  import bvm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state_r, state_nxt;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (status.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: if (start) state_nxt = ST_RDX;
      ST_RDX:  state_nxt = ST_RDY;
      ST_RDY:  state_nxt = ST_EXEC;
      ST_EXEC: begin
        unique case (status.path)
          PATH_BCD:   state_nxt = ST_BCD;
          PATH_STORE: state_nxt = ST_STO;
          PATH_LOAD:  state_nxt = ST_LRD;
          PATH_DRAW:  state_nxt = status.n_zero ? ST_FIN : ST_DRD;
          default:    state_nxt = ST_FIN;
        endcase
      end
      ST_BCD:  if (status.cnt_eq_2) state_nxt = ST_FIN;
      ST_STO:  if (status.cnt_eq_x) state_nxt = ST_FIN;
      ST_LRD:  state_nxt = ST_LWR;
      ST_LWR:  state_nxt = status.cnt_eq_x ? ST_FIN : ST_LRD;
      ST_DRD:  state_nxt = ST_DWR;
      ST_DWR:  state_nxt = status.cnt_eq_nm1 ? ST_FIN : ST_DRD;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign cmd.step = state_r;
  assign cmd.load = (state_r == ST_IDLE) && start;

  // An accepted item always starts with the register reads.
  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> (state_r == ST_RDX))
    else $error("accepted item did not enter register read");

  // The finishing cycle always hands control back to idle.
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> (state_r == ST_IDLE))
    else $error("finish did not return to idle");

  // The execute cycle is always preceded by the second register read.
  a_exec_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> ($past(state_r) == ST_RDY))
    else $error("execute entered without operand reads");

endmodule

### rtl/core/bvm_dpath.sv
// Datapath: machine state, memory, screen, ALU and the result register.
module bvm_dpath
  import bvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_opcode,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [4:0]  in_row,
  input  logic [3:0]  in_reg_index,
  output logic        out_valid,
  output logic [11:0] out_next_pc,
  output logic [11:0] out_index_value,
  output logic [63:0] out_read_value,
  output logic        out_drew
);

  // Decimal digit of an 8-bit value by reciprocal multiplies.
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [13:0] ph;
    logic [1:0]  h;
    logic [6:0]  rem;
    logic [14:0] pt;
    logic [3:0]  t;
    logic [3:0]  one;
    ph  = 14'(v) * 14'd41;
    h   = ph[13:12];
    rem = 7'(v - 8'(h) * 8'd100);
    pt  = 15'(rem) * 15'd205;
    t   = pt[14:11];
    one = 4'(rem - 7'(t) * 7'd10);
    unique case (sel)
      2'd0:    bcd_digit = {6'b0, h};
      2'd1:    bcd_digit = {4'b0, t};
      default: bcd_digit = {4'b0, one};
    endcase
  endfunction

  // Architectural state.
  logic [11:0] pc_r, idx_r;
  logic [7:0]  gp_r [16];
  logic [11:0] stk_r [16];
  logic [3:0]  sp_r;
  logic [7:0]  dly_r, snd_r;
  logic [63:0] scr_r [ScrRows];
  logic [MemAw-1:0] clr_cnt_r;
  logic [3:0]  cnt_r;
  logic        hit_r;
  logic        out_valid_r;

  // Latched item and operands.
  logic [2:0]  kind_r;
  logic [15:0] op_r;
  logic [11:0] addr_r;
  logic [7:0]  data_r;
  logic [4:0]  row_r;
  logic [3:0]  ri_r;
  logic [7:0]  vx_r, vy_r;
  logic [63:0] rv_r;
  logic [11:0] out_pc_r, out_idx_r;
  logic [63:0] out_rv_r;
  logic        out_drew_r;

  // Opcode fields.
  logic [3:0]  top, fx, fy, fn;
  logic [7:0]  nn;
  logic [11:0] nnn;
  assign top = op_r[15:12];
  assign fx  = op_r[11:8];
  assign fy  = op_r[7:4];
  assign fn  = op_r[3:0];
  assign nn  = op_r[7:0];
  assign nnn = op_r[11:0];

  logic is_exec;
  assign is_exec = (kind_r == KIND_EXEC);

  // Sequence selection for the controller.
  path_t path;
  always_comb begin
    path = PATH_SIMPLE;
    if (is_exec && top == TOP_DRAW) begin
      path = PATH_DRAW;
    end else if (is_exec && top == TOP_MISC) begin
      if (nn == MISC_BCD) path = PATH_BCD;
      else if (nn == MISC_STORE) path = PATH_STORE;
      else if (nn == MISC_LOAD) path = PATH_LOAD;
    end
  end

  assign status.path       = path;
  assign status.clr_last   = (clr_cnt_r == {MemAw{1'b1}});
  assign status.cnt_eq_x   = (cnt_r == fx);
  assign status.cnt_eq_2   = (cnt_r == 4'd2);
  assign status.cnt_eq_nm1 = (cnt_r == fn - 4'd1);
  assign status.n_zero     = (fn == 4'd0);

  // Single register-file read port, address set by the step.
  logic [3:0] gp_ra;
  logic [7:0] gp_rd;
  always_comb begin
    gp_ra = fx;
    unique case (cmd.step)
      ST_RDY:  gp_ra = (top == TOP_JPV0) ? 4'd0 : fy;
      ST_EXEC: gp_ra = ri_r;
      ST_STO:  gp_ra = cnt_r;
      default: gp_ra = fx;
    endcase
  end
  assign gp_rd = gp_r[gp_ra];

  // Memory port control.
  logic [11:0] mem_a;
  logic        ram_we;
  logic [11:0] ram_wa, ram_ra;
  logic [7:0]  ram_wd, ram_rd;
  logic [6:0]  font_a;
  assign mem_a  = idx_r + {8'b0, cnt_r};
  assign font_a = clr_cnt_r[6:0];

  always_comb begin
    ram_we = 1'b0;
    ram_wa = mem_a;
    ram_wd = gp_rd;
    ram_ra = mem_a;
    unique case (cmd.step)
      ST_CLR: begin
        ram_we = 1'b1;
        ram_wa = clr_cnt_r;
        ram_wd = (clr_cnt_r < 12'(FontLen)) ? FONT[font_a] : 8'd0;
      end
      ST_EXEC: begin
        ram_we = (kind_r == KIND_WRITE);
        ram_wa = addr_r;
        ram_wd = data_r;
        ram_ra = addr_r;
      end
      ST_BCD: begin
        ram_we = 1'b1;
        ram_wd = bcd_digit(vx_r, cnt_r[1:0]);
      end
      ST_STO:  ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  bvm_ram #(.WIDTH(8), .DEPTH(MemDepth)) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  // ALU for the 8XYn group.
  logic [8:0] sum9;
  logic       alu_we, alu_fwe, alu_flag;
  logic [7:0] alu_res;
  assign sum9 = {1'b0, vx_r} + {1'b0, vy_r};
  always_comb begin
    alu_we   = 1'b1;
    alu_fwe  = 1'b0;
    alu_flag = 1'b0;
    alu_res  = vy_r;
    unique case (fn)
      ALU_MOV: alu_res = vy_r;
      ALU_OR:  alu_res = vx_r | vy_r;
      ALU_AND: alu_res = vx_r & vy_r;
      ALU_XOR: alu_res = vx_r ^ vy_r;
      ALU_ADD: begin
        alu_res = sum9[7:0]; alu_fwe = 1'b1; alu_flag = sum9[8];
      end
      ALU_SUB: begin
        alu_res = vx_r - vy_r; alu_fwe = 1'b1; alu_flag = (vx_r >= vy_r);
      end
      ALU_SHR: begin
        alu_res = {1'b0, vx_r[7:1]}; alu_fwe = 1'b1; alu_flag = vx_r[0];
      end
      ALU_SUBN: begin
        alu_res = vy_r - vx_r; alu_fwe = 1'b1; alu_flag = (vy_r >= vx_r);
      end
      ALU_SHL: begin
        alu_res = {vx_r[6:0], 1'b0}; alu_fwe = 1'b1; alu_flag = vx_r[7];
      end
      default: alu_we = 1'b0;
    endcase
  end

  // Sprite row: byte reversed so bit 7 lands at column Vx, then rotated.
  logic [63:0]  spr_base, spr_mask;
  logic [127:0] spr_wide;
  logic [4:0]   drow;
  always_comb begin
    spr_base = '0;
    for (int j = 0; j < 8; j++) begin
      spr_base[j] = ram_rd[7 - j];
    end
  end
  assign spr_wide = {spr_base, spr_base} << vx_r[5:0];
  assign spr_mask = spr_wide[127:64];
  assign drow     = vy_r[4:0] + {1'b0, cnt_r};

  // Index after the block store or load advances it.
  logic [11:0] idx_fin;
  assign idx_fin = (path == PATH_STORE || path == PATH_LOAD) ?
                   idx_r + {8'b0, fx} + 12'd1 : idx_r;

  logic [3:0] sp_inc;
  assign sp_inc = sp_r + 4'd1;

  // Architectural state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_RESET;
      idx_r       <= '0;
      sp_r        <= '0;
      dly_r       <= '0;
      snd_r       <= '0;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        gp_r[i]  <= '0;
        stk_r[i] <= '0;
      end
      for (int i = 0; i < ScrRows; i++) begin
        scr_r[i] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      unique case (cmd.step)
        ST_CLR: clr_cnt_r <= clr_cnt_r + 12'd1;
        ST_EXEC: begin
          cnt_r <= '0;
          hit_r <= 1'b0;
          if (is_exec) begin
            unique case (top)
              TOP_SYS: begin
                if (op_r == OP_CLS) begin
                  for (int i = 0; i < ScrRows; i++) begin
                    scr_r[i] <= '0;
                  end
                end else if (op_r == OP_RET) begin
                  pc_r <= stk_r[sp_r];
                  sp_r <= sp_r - 4'd1;
                end
              end
              TOP_JP: pc_r <= nnn;
              TOP_CALL: begin
                sp_r <= sp_inc;
                stk_r[sp_inc] <= pc_r;
                pc_r <= nnn;
              end
              TOP_SEQI: if (vx_r == nn) pc_r <= pc_r + 12'd2;
              TOP_SNEI: if (vx_r != nn) pc_r <= pc_r + 12'd2;
              TOP_SEQ:  if (vx_r == vy_r) pc_r <= pc_r + 12'd2;
              TOP_SNE:  if (vx_r != vy_r) pc_r <= pc_r + 12'd2;
              TOP_LDI:  gp_r[fx] <= nn;
              TOP_ADDI: gp_r[fx] <= vx_r + nn;
              TOP_ALU: begin
                if (alu_we) gp_r[fx] <= alu_res;
                if (alu_fwe) gp_r[15] <= {7'b0, alu_flag};
              end
              TOP_LDIDX: idx_r <= nnn;
              TOP_JPV0:  pc_r <= nnn + {4'b0, vy_r};
              TOP_MISC: begin
                unique case (nn)
                  MISC_GETDT: gp_r[fx] <= dly_r;
                  MISC_SETDT: dly_r <= vx_r;
                  MISC_SETST: snd_r <= vx_r;
                  MISC_ADDI:  idx_r <= idx_r + {4'b0, vx_r};
                  MISC_FONT:  idx_r <= 12'({4'b0, vx_r} * 12'd5);
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end
        ST_BCD, ST_STO: cnt_r <= cnt_r + 4'd1;
        ST_LWR: begin
          gp_r[cnt_r] <= ram_rd;
          cnt_r <= cnt_r + 4'd1;
        end
        ST_DWR: begin
          scr_r[drow] <= scr_r[drow] ^ spr_mask;
          if ((scr_r[drow] & spr_mask) != '0) hit_r <= 1'b1;
          cnt_r <= cnt_r + 4'd1;
        end
        ST_FIN: begin
          idx_r <= idx_fin;
          if (path == PATH_DRAW) gp_r[15] <= {7'b0, hit_r};
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Item latch, operand registers and result fields.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      op_r   <= in_opcode;
      addr_r <= in_address;
      data_r <= in_data;
      row_r  <= in_row;
      ri_r   <= in_reg_index;
    end
    if (cmd.step == ST_RDX) vx_r <= gp_rd;
    if (cmd.step == ST_RDY) vy_r <= gp_rd;
    if (cmd.step == ST_EXEC) begin
      unique case (kind_r)
        KIND_RDSCR: rv_r <= scr_r[row_r];
        KIND_RDREG: rv_r <= {56'b0, gp_rd};
        default:    rv_r <= '0;
      endcase
    end
    if (cmd.step == ST_FIN) begin
      out_pc_r   <= pc_r;
      out_idx_r  <= idx_fin;
      out_rv_r   <= (kind_r == KIND_RDMEM) ? {56'b0, ram_rd} : rv_r;
      out_drew_r <= is_exec && (op_r == OP_CLS || top == TOP_DRAW);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_pc_r;
  assign out_index_value = out_idx_r;
  assign out_read_value  = out_rv_r;
  assign out_drew        = out_drew_r;

endmodule

### rtl/core/bytecode_vm_instruction_execute_top.sv
// Top level of the CHIP-8 instruction execute block.
//
// Input beat: in_kind with its operand fields, taken when start is high
// and busy is low. Kinds are execute opcode, write memory byte, read
// memory byte, read screen row and read register.
// Result beat: out_valid strobes for one cycle with out_next_pc,
// out_index_value, out_read_value and out_drew; there is exactly one
// result per input beat and the receiver must take it in that cycle.
// Sequence: most items pass through two register-file reads, execute,
// finish and the output register. FX33 adds a step per BCD digit, FX55
// a store step per register V0..VX, and FX65 and DXYN a read step and a
// write step per byte, set by the single memory port and its registered
// read, so the longest item is FX65 with X=15.
// Throughput: one item at a time; start may be raised again in the
// cycle the result strobes.
// Reset: rst_n is synchronous, active low. After reset the block passes
// over all 4096 memory bytes, loading the font and zeroing the rest; busy
// stays high during it. PC resets to 0x200, other architectural state to zero.
module bytecode_vm_instruction_execute_top
  import bvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_opcode,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [4:0]  in_row,
  input  logic [3:0]  in_reg_index,
  output logic        out_valid,
  output logic [11:0] out_next_pc,
  output logic [11:0] out_index_value,
  output logic [63:0] out_read_value,
  output logic        out_drew
);

  cmd_t    cmd;
  status_t status;

  bvm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  bvm_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_kind         (in_kind),
    .in_opcode       (in_opcode),
    .in_address      (in_address),
    .in_data         (in_data),
    .in_row          (in_row),
    .in_reg_index    (in_reg_index),
    .out_valid       (out_valid),
    .out_next_pc     (out_next_pc),
    .out_index_value (out_index_value),
    .out_read_value  (out_read_value),
    .out_drew        (out_drew)
  );

  // A result beat lasts one cycle only.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // The block is ready again while its result is shown.
  a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while result strobes");

endmodule

### test/bytecode_vm_instruction_execute_top_tb.sv
// Self-checking testbench for the CHIP-8 instruction execute block.
module bytecode_vm_instruction_execute_top_tb
  import bvm_pkg::*;
;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] opcode;
    logic [11:0] address;
    logic [7:0]  data;
    logic [4:0]  row;
    logic [3:0]  reg_index;
  } beat_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [11:0] index_value;
    logic [63:0] read_value;
    logic        drew;
  } outcome_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_kind;
  logic [15:0] in_opcode;
  logic [11:0] in_address;
  logic [7:0]  in_data;
  logic [4:0]  in_row;
  logic [3:0]  in_reg_index;
  logic        out_valid;
  logic [11:0] out_next_pc;
  logic [11:0] out_index_value;
  logic [63:0] out_read_value;
  logic        out_drew;

  // Machine state kept by the predictor.
  logic [11:0] m_pc;
  logic [11:0] m_index;
  logic [7:0]  m_v [16];
  logic [11:0] m_stack [16];
  logic [3:0]  m_sp;
  logic [7:0]  m_delay;
  logic [7:0]  m_sound;
  logic [7:0]  m_mem [MemDepth];
  logic [63:0] m_screen [ScrRows];

  beat_t    pending_beats[$];
  outcome_t expected_outcomes[$];
  int       error_count;
  bit       stimulus_done;
  bit       hold_sender;
  int       gap_left;
  int       burst_left;

  bytecode_vm_instruction_execute_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_opcode(in_opcode), .in_address(in_address),
    .in_data(in_data), .in_row(in_row), .in_reg_index(in_reg_index),
    .out_valid(out_valid), .out_next_pc(out_next_pc),
    .out_index_value(out_index_value), .out_read_value(out_read_value),
    .out_drew(out_drew)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Set the predicted machine to its post-reset contents.
  task automatic reset_machine();
    m_pc = PC_RESET;
    m_index = '0;
    m_sp = '0;
    m_delay = '0;
    m_sound = '0;
    for (int i = 0; i < 16; i++) begin
      m_v[i] = '0;
      m_stack[i] = '0;
    end
    for (int i = 0; i < MemDepth; i++) m_mem[i] = (i < FontLen) ? FONT[i] : 8'h00;
    for (int i = 0; i < ScrRows; i++) m_screen[i] = '0;
  endtask

  // Register-to-register arithmetic; the flag lands in VF after the result.
  function automatic void run_alu(input logic [3:0] x, input logic [3:0] y,
                                  input logic [3:0] sub);
    logic [7:0] vx;
    logic [7:0] vy;
    logic [8:0] sum;
    logic       flag;
    vx = m_v[x];
    vy = m_v[y];
    flag = 1'b0;
    case (sub)
      ALU_MOV: m_v[x] = vy;
      ALU_OR:  m_v[x] = vx | vy;
      ALU_AND: m_v[x] = vx & vy;
      ALU_XOR: m_v[x] = vx ^ vy;
      ALU_ADD: begin
        sum = vx + vy;
        m_v[x] = sum[7:0];
        m_v[15] = {7'd0, sum[8]};
      end
      ALU_SUB: begin
        flag = vx >= vy;
        m_v[x] = vx - vy;
        m_v[15] = {7'd0, flag};
      end
      ALU_SHR: begin
        m_v[x] = vx >> 1;
        m_v[15] = {7'd0, vx[0]};
      end
      ALU_SUBN: begin
        flag = vy >= vx;
        m_v[x] = vy - vx;
        m_v[15] = {7'd0, flag};
      end
      ALU_SHL: begin
        m_v[x] = vx << 1;
        m_v[15] = {7'd0, vx[7]};
      end
      default: ;
    endcase
  endfunction

  // The FXnn group: timers, index arithmetic, font address, BCD and block moves.
  function automatic void run_misc(input logic [3:0] x, input logic [7:0] nn);
    logic [7:0]  vx;
    logic [11:0] a;
    vx = m_v[x];
    case (nn)
      MISC_GETDT: m_v[x] = m_delay;
      MISC_SETDT: m_delay = vx;
      MISC_SETST: m_sound = vx;
      MISC_ADDI:  m_index = m_index + vx;
      MISC_FONT:  m_index = vx * 12'd5;
      MISC_BCD: begin
        a = m_index;
        m_mem[a] = vx / 100;
        a = a + 1;
        m_mem[a] = (vx / 10) % 10;
        a = a + 1;
        m_mem[a] = vx % 10;
      end
      MISC_STORE: begin
        for (int i = 0; i <= x; i++) begin
          a = m_index + i;
          m_mem[a] = m_v[i];
        end
        m_index = m_index + x + 1;
      end
      MISC_LOAD: begin
        for (int i = 0; i <= x; i++) begin
          a = m_index + i;
          m_v[i] = m_mem[a];
        end
        m_index = m_index + x + 1;
      end
      default: ;
    endcase
  endfunction

  // Sprite draw with row and column wrap; VF reports a collision.
  function automatic void run_draw(input logic [3:0] x, input logic [3:0] y,
                                   input logic [3:0] n);
    logic [5:0]  px;
    logic [4:0]  r;
    logic [7:0]  b;
    logic [11:0] a;
    logic [63:0] mask;
    logic [5:0]  col;
    logic        hit;
    px = m_v[x][5:0];
    hit = 1'b0;
    for (int i = 0; i < n; i++) begin
      r = m_v[y][4:0] + i;
      a = m_index + i;
      b = m_mem[a];
      mask = '0;
      for (int j = 0; j < 8; j++) begin
        col = px + j;
        if (b[7 - j]) mask[col] = 1'b1;
      end
      if ((m_screen[r] & mask) != 0) hit = 1'b1;
      m_screen[r] = m_screen[r] ^ mask;
    end
    m_v[15] = {7'd0, hit};
  endfunction

  // Apply one beat to the predicted machine and return its outcome.
  function automatic outcome_t predict_outcome(input beat_t b);
    outcome_t o;
    logic [3:0] top;
    logic [3:0] x;
    logic [3:0] y;
    logic [7:0] nn;
    o = '0;
    top = b.opcode[15:12];
    x = b.opcode[11:8];
    y = b.opcode[7:4];
    nn = b.opcode[7:0];
    case (b.kind)
      KIND_EXEC: begin
        case (top)
          TOP_SYS: begin
            if (b.opcode == OP_CLS) begin
              for (int i = 0; i < ScrRows; i++) m_screen[i] = '0;
              o.drew = 1'b1;
            end else if (b.opcode == OP_RET) begin
              m_pc = m_stack[m_sp];
              m_sp = m_sp - 1;
            end
          end
          TOP_JP: m_pc = b.opcode[11:0];
          TOP_CALL: begin
            m_sp = m_sp + 1;
            m_stack[m_sp] = m_pc;
            m_pc = b.opcode[11:0];
          end
          TOP_SEQI: if (m_v[x] == nn) m_pc = m_pc + 2;
          TOP_SNEI: if (m_v[x] != nn) m_pc = m_pc + 2;
          TOP_SEQ:  if (m_v[x] == m_v[y]) m_pc = m_pc + 2;
          TOP_LDI:  m_v[x] = nn;
          TOP_ADDI: m_v[x] = m_v[x] + nn;
          TOP_ALU:  run_alu(x, y, b.opcode[3:0]);
          TOP_SNE:  if (m_v[x] != m_v[y]) m_pc = m_pc + 2;
          TOP_LDIDX: m_index = b.opcode[11:0];
          TOP_JPV0: m_pc = b.opcode[11:0] + m_v[0];
          TOP_DRAW: begin
            run_draw(x, y, b.opcode[3:0]);
            o.drew = 1'b1;
          end
          TOP_MISC: run_misc(x, nn);
          default: ;
        endcase
      end
      KIND_WRITE: m_mem[b.address] = b.data;
      KIND_RDMEM: o.read_value = {56'd0, m_mem[b.address]};
      KIND_RDSCR: o.read_value = m_screen[b.row];
      KIND_RDREG: o.read_value = {56'd0, m_v[b.reg_index]};
      default: ;
    endcase
    o.next_pc = m_pc;
    o.index_value = m_index;
    return o;
  endfunction

  function automatic beat_t exec_beat(input logic [15:0] op);
    beat_t b;
    b = beat_t'({$urandom, $urandom});
    b.kind = KIND_EXEC;
    b.opcode = op;
    return b;
  endfunction

  // Random opcode, weighted toward the implemented instructions.
  function automatic logic [15:0] random_opcode();
    logic [15:0] op;
    logic [3:0]  sel;
    op = $urandom;
    sel = $urandom_range(0, 15);
    case (sel)
      0: op[15:12] = TOP_LDI;
      1: op[15:12] = TOP_ADDI;
      2, 3: op[15:12] = TOP_ALU;
      4: begin
        op[15:12] = TOP_DRAW;
        if ($urandom_range(0, 3) != 0) op[3:0] = $urandom_range(1, 5);
      end
      5: op = {TOP_MISC, op[11:8], ($urandom_range(0, 1) != 0) ? MISC_STORE : MISC_LOAD};
      6: op = {TOP_MISC, op[11:8], MISC_BCD};
      7: begin
        case ($urandom_range(0, 4))
          0: op[7:0] = MISC_GETDT;
          1: op[7:0] = MISC_SETDT;
          2: op[7:0] = MISC_SETST;
          3: op[7:0] = MISC_ADDI;
          default: op[7:0] = MISC_FONT;
        endcase
        op[15:12] = TOP_MISC;
      end
      8: op = ($urandom_range(0, 1) != 0) ? OP_RET : OP_CLS;
      9: op[15:12] = TOP_LDIDX;
      default: ;
    endcase
    return op;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    b = beat_t'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: b.kind = KIND_WRITE;
      1: b.kind = KIND_RDMEM;
      2: b.kind = KIND_RDSCR;
      3: b.kind = KIND_RDREG;
      4: b.kind = $urandom_range(5, 7);
      default: begin
        b.kind = KIND_EXEC;
        b.opcode = random_opcode();
      end
    endcase
    return b;
  endfunction

  // Stimulus: directed opcodes first, then random beats with one full drain.
  initial begin
    beat_t b;
    error_count = 0;
    stimulus_done = 1'b0;
    hold_sender = 1'b0;
    reset_machine();
    pending_beats.push_back(exec_beat({TOP_LDI, 4'h0, 8'hFF}));
    pending_beats.push_back(exec_beat({TOP_LDI, 4'h1, 8'h01}));
    pending_beats.push_back(exec_beat({TOP_ALU, 4'h0, 4'h1, ALU_ADD}));
    pending_beats.push_back(exec_beat({TOP_ALU, 4'hF, 4'h1, ALU_SUB}));
    pending_beats.push_back(exec_beat({TOP_ALU, 4'h1, 4'h0, ALU_SUBN}));
    pending_beats.push_back(exec_beat({TOP_ALU, 4'h1, 4'h1, ALU_SHL}));
    pending_beats.push_back(exec_beat({TOP_ALU, 4'h1, 4'h1, ALU_SHR}));
    pending_beats.push_back(exec_beat({TOP_CALL, 12'hFFF}));
    pending_beats.push_back(exec_beat(OP_RET));
    pending_beats.push_back(exec_beat(OP_RET));
    pending_beats.push_back(exec_beat({TOP_LDI, 4'h0, 8'hFF}));
    pending_beats.push_back(exec_beat({TOP_JPV0, 12'hFFF}));
    pending_beats.push_back(exec_beat({TOP_SEQ, 4'h2, 4'h3, 4'hF}));
    pending_beats.push_back(exec_beat({TOP_SNEI, 4'h2, 8'h00}));
    pending_beats.push_back(exec_beat({TOP_LDIDX, 12'hFFE}));
    pending_beats.push_back(exec_beat({TOP_MISC, 4'h0, MISC_BCD}));
    pending_beats.push_back(exec_beat({TOP_MISC, 4'hF, MISC_STORE}));
    pending_beats.push_back(exec_beat({TOP_MISC, 4'hF, MISC_LOAD}));
    pending_beats.push_back(exec_beat({TOP_MISC, 4'h0, MISC_FONT}));
    pending_beats.push_back(exec_beat({TOP_DRAW, 4'h0, 4'h1, 4'hF}));
    pending_beats.push_back(exec_beat({TOP_DRAW, 4'h0, 4'h1, 4'hF}));
    pending_beats.push_back(exec_beat({TOP_DRAW, 4'h0, 4'h1, 4'h0}));
    b = exec_beat(16'h0000);
    b.kind = KIND_RDSCR;
    b.row = 5'd31;
    pending_beats.push_back(b);
    pending_beats.push_back(exec_beat(OP_CLS));
    for (int i = 0; i < 800; i++) pending_beats.push_back(random_beat());
    wait (pending_beats.size() == 0);
    hold_sender = 1'b1;
    wait (expected_outcomes.size() == 0);
    hold_sender = 1'b0;
    for (int i = 0; i < 800; i++) pending_beats.push_back(random_beat());
    wait (pending_beats.size() == 0);
    stimulus_done = 1'b1;
  end

  // Driver: bursts of beats separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (start && !busy) begin
      // The beat on the ports was taken at this edge.
      expected_outcomes.push_back(predict_outcome(pending_beats.pop_front()));
      if (burst_left > 0 && pending_beats.size() > 0 && !hold_sender) begin
        burst_left <= burst_left - 1;
        {in_kind, in_opcode, in_address, in_data, in_row, in_reg_index} <= pending_beats[0];
      end else begin
        start <= 1'b0;
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_beats.size() > 0 && !hold_sender) begin
        start <= 1'b1;
        burst_left <= $urandom_range(0, 20);
        {in_kind, in_opcode, in_address, in_data, in_row, in_reg_index} <= pending_beats[0];
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual pc=%h", $time, out_next_pc);
        error_count++;
      end else begin
        e = expected_outcomes.pop_front();
        if (out_next_pc !== e.next_pc) begin
          $display("%0t: next_pc expected %h actual %h", $time, e.next_pc, out_next_pc);
          error_count++;
        end
        if (out_index_value !== e.index_value) begin
          $display("%0t: index_value expected %h actual %h", $time, e.index_value,
                   out_index_value);
          error_count++;
        end
        if (out_read_value !== e.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, e.read_value,
                   out_read_value);
          error_count++;
        end
        if (out_drew !== e.drew) begin
          $display("%0t: drew expected %b actual %b", $time, e.drew, out_drew);
          error_count++;
        end
      end
    end
  end

  // Reset, then wait for the drain and the final quiet period.
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = '0;
    in_opcode = '0;
    in_address = '0;
    in_data = '0;
    in_row = '0;
    in_reg_index = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && expected_outcomes.size() == 0);
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10000000;
    $display("simulation failed");
    $finish;
  end

endmodule
